FILE: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on clk with reset on rst_n
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define LSV_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked on every clock edge outside reset
`define LSV_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: rtl/lsv_pkg.sv
// ---------------------------------------------------------------------------
// lsv_pkg
// types and constants of the looping sample voice
// ---------------------------------------------------------------------------
package lsv_pkg;

    localparam int MEM_DEPTH = 65536;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);
    localparam int APB_AW    = 5;
    localparam int APB_DW    = 32;

    localparam logic [15:0] PERIOD_RST = 16'd428;
    localparam logic [16:0] LEN_MAX    = 17'd65536;

    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_LOAD  = 2'd1,
        KIND_START = 2'd2,
        KIND_NOP   = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        REG_PERIOD    = 3'd0,
        REG_VOLUME    = 3'd1,
        REG_SAMPLE_LEN = 3'd2,
        REG_LOOP_LEN  = 3'd3,
        REG_START_OFS = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [15:0] period;
        logic [6:0]  volume;
        logic [16:0] sample_length;
        logic [16:0] loop_length;
        logic [15:0] start_offset;
    } cfg_t;

    // sample length clamped to 1..65536
    function automatic logic [16:0] eff_length(input logic [16:0] len);
        logic [16:0] r;
        r = len;
        if (len == 17'd0)
            r = 17'd1;
        else if (len > LEN_MAX)
            r = LEN_MAX;
        return r;
    endfunction

    function automatic logic [MEM_AW-1:0] mem_index(input logic [15:0] a);
        return MEM_AW'(a);
    endfunction

endpackage

FILE: rtl/lsv_regs.sv
// ---------------------------------------------------------------------------
// lsv_regs
// apb register file holding the voice configuration
// ---------------------------------------------------------------------------
module lsv_regs
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [lsv_pkg::APB_AW-1:0] paddr,
    input  logic [lsv_pkg::APB_DW-1:0] pwdata,
    output logic [lsv_pkg::APB_DW-1:0] prdata,
    output logic                      pready,
    output lsv_pkg::cfg_t             cfg
);
    import lsv_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[APB_AW-1:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.period        <= PERIOD_RST;
            cfg_reg.volume        <= 7'd0;
            cfg_reg.sample_length <= 17'd1;
            cfg_reg.loop_length   <= 17'd1;
            cfg_reg.start_offset  <= 16'd0;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_PERIOD:     cfg_reg.period        <= pwdata[15:0];
                REG_VOLUME:     cfg_reg.volume        <= pwdata[6:0];
                REG_SAMPLE_LEN: cfg_reg.sample_length <= pwdata[16:0];
                REG_LOOP_LEN:   cfg_reg.loop_length   <= pwdata[16:0];
                REG_START_OFS:  cfg_reg.start_offset  <= pwdata[15:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_PERIOD:     prdata = {16'd0, cfg_reg.period};
            REG_VOLUME:     prdata = {25'd0, cfg_reg.volume};
            REG_SAMPLE_LEN: prdata = {15'd0, cfg_reg.sample_length};
            REG_LOOP_LEN:   prdata = {15'd0, cfg_reg.loop_length};
            REG_START_OFS:  prdata = {16'd0, cfg_reg.start_offset};
            default:        prdata = '0;
        endcase
    end

endmodule

FILE: rtl/looped_sample_voice_pwm_volume.sv
// ---------------------------------------------------------------------------
// looped_sample_voice_pwm_volume
// one looping sample playback voice with pwm volume gating
// ---------------------------------------------------------------------------
// Takes one beat per clock while s_tready is high and returns one result beat
// for each through the second stage and the output register. Position, divider
// and pwm counters update at the accept edge; a fetching tick reads the 64K-byte
// sample memory in that same edge; the second stage picks up the registered
// read byte as the held byte and gates it. Loads write the memory at their
// accept edge, so a following tick sees the new byte with no stall. With the
// output held off, two results queue before s_tready drops.
module looped_sample_voice_pwm_volume
(
    input  logic                       clk,
    input  logic                       rst_n,
    // apb configuration
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [lsv_pkg::APB_AW-1:0] paddr,
    input  logic [lsv_pkg::APB_DW-1:0] pwdata,
    output logic [lsv_pkg::APB_DW-1:0] prdata,
    output logic                       pready,
    // input stream
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [23:0]                s_tdata,  // load_address[15:0], load_byte[23:16]
    input  logic [1:0]                 s_tuser,  // kind[1:0]
    // result stream
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [23:0]                m_tdata,  // sample_out[7:0], position[23:8]
    output logic [0:0]                 m_tuser   // audible[0]
);
    import lsv_pkg::*;

    cfg_t cfg;

    lsv_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // sample memory
    logic [7:0]        mem [MEM_DEPTH];
    logic [7:0]        rdata_reg;
    logic              mem_wr;
    logic              mem_rd;

    // voice state
    logic              active_reg, active_next;
    logic [15:0]       pos_reg, pos_next;
    logic [15:0]       div_reg, div_next;
    logic [5:0]        pwm_reg, pwm_next;
    logic [7:0]        held_reg, held_next;

    // second stage
    logic              s1_valid_reg;
    logic              s1_fetch_reg;
    logic              s1_aud_reg;
    logic [15:0]       s1_pos_reg;

    // output register
    logic              out_valid_reg;
    logic [7:0]        out_sample_reg;
    logic              out_aud_reg;
    logic [15:0]       out_pos_reg;

    logic              accept;
    logic              advance;
    kind_t             kind;
    logic [15:0]       load_address;
    logic [7:0]        load_byte;
    logic              run;
    logic              fetch;
    logic              aud;
    logic [16:0]       len;
    logic [16:0]       loop_len;
    logic [16:0]       pos_inc;
    logic [15:0]       div_base;
    logic [7:0]        smp;

    assign kind         = kind_t'(s_tuser);
    assign load_address = s_tdata[15:0];
    assign load_byte    = s_tdata[23:16];

    assign advance  = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || advance;
    assign accept   = s_tvalid && s_tready;

    assign len  = eff_length(cfg.sample_length);
    assign run  = (kind == KIND_TICK) && active_reg && (cfg.volume != 7'd0);
    assign fetch = run && (div_reg == 16'd0);
    assign aud  = run && ({1'b0, pwm_reg} < cfg.volume);

    assign mem_wr = accept && (kind == KIND_LOAD);
    assign mem_rd = accept && fetch;

    always_comb
    begin
        active_next = active_reg;
        pos_next    = pos_reg;
        div_next    = div_reg;
        pwm_next    = pwm_reg;
        pos_inc     = {1'b0, pos_reg} + 17'd1;
        loop_len    = cfg.loop_length;
        if (loop_len == 17'd0)
            loop_len = 17'd1;
        if (loop_len > len)
            loop_len = len;
        div_base = fetch ? cfg.period : div_reg;

        case (kind)
            KIND_START:
            begin
                active_next = 1'b1;
                if ({1'b0, cfg.start_offset} < len - 17'd1)
                    pos_next = cfg.start_offset;
                else
                    pos_next = 16'(len - 17'd1);
            end
            KIND_TICK:
            begin
                if (run)
                begin
                    if (fetch)
                    begin
                        // wrap back by the loop length after the last byte
                        if (pos_inc == len)
                            pos_next = 16'(len - loop_len);
                        else
                            pos_next = pos_inc[15:0];
                    end
                    pwm_next = pwm_reg + 6'd1;
                    div_next = div_base - 16'd1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_wr)
            mem[mem_index(load_address)] <= load_byte;
        if (mem_rd)
            rdata_reg <= mem[mem_index(pos_reg)];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            pos_reg    <= 16'd0;
            div_reg    <= 16'd0;
            pwm_reg    <= 6'd0;
        end
        else if (accept)
        begin
            active_reg <= active_next;
            pos_reg    <= pos_next;
            div_reg    <= div_next;
            pwm_reg    <= pwm_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s_tready)
            s1_valid_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_fetch_reg <= fetch;
            s1_aud_reg   <= aud;
            s1_pos_reg   <= pos_next;
        end
    end

    // the fetched byte becomes the held byte for this and later ticks
    assign smp       = s1_fetch_reg ? rdata_reg : held_reg;
    assign held_next = advance ? smp : held_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg      <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            held_reg <= held_next;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_sample_reg <= s1_aud_reg ? smp : 8'd0;
            out_aud_reg    <= s1_aud_reg;
            out_pos_reg    <= s1_pos_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_pos_reg, out_sample_reg};
    assign m_tuser  = out_aud_reg;

endmodule

FILE: rtl/lsv_checker.sv
// ---------------------------------------------------------------------------
// lsv_checker
// port-level checks on the looping sample voice
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module lsv_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        pready,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    input  logic [0:0]  m_tuser
);

    // a silent beat carries a zero sample
    `LSV_ASSERT_IMP(a_silent_zero,
                    m_tvalid && !m_tuser[0],
                    m_tdata[7:0] == 8'd0,
                    "silent beat has nonzero sample")

    // a stalled result beat holds
    `LSV_ASSERT(a_out_hold,
                (m_tvalid && !m_tready) |=>
                    (m_tvalid && $stable(m_tdata) && $stable(m_tuser)),
                "stalled result beat changed")

    // register port never waits
    `LSV_ASSERT(a_pready, pready, "pready dropped")

    // no result beat right after reset release
    `LSV_ASSERT_IMP(a_reset_empty,
                    !$past(rst_n),
                    !m_tvalid,
                    "result beat right after reset")

endmodule

bind looped_sample_voice_pwm_volume lsv_checker u_lsv_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .pready   (pready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

FILE: verif/looped_sample_voice_pwm_volume_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// looped_sample_voice_pwm_volume_tb
// self-checking bench for the looping sample voice with pwm volume
// ----------------------------------------------------------------------------
// Streams tick, load, start and no-op beats into the voice and checks every
// result beat against a cycle-free model of the voice that is advanced at each
// accepted input beat. Settings change over apb between phases only. A short
// directed run covers the edge settings, then random phases mix sender gaps,
// receiver stalls and one long output hold-off. Before a tick that would fetch
// from a cell never loaded, the stimulus loads that cell first.
// ----------------------------------------------------------------------------
module looped_sample_voice_pwm_volume_tb;
    import lsv_pkg::*;

    localparam int QUIET_LIMIT = 20000;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASES      = 10;
    localparam int PHASE_BEATS = 155;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] addr;
        logic [7:0]  data;
    } voice_beat_t;

    typedef struct packed {
        logic [7:0]  sample;
        logic        audible;
        logic [15:0] position;
    } voice_res_t;

    typedef struct packed {
        logic        active;
        logic [15:0] pos;
        logic [15:0] div;
        logic [5:0]  pwm;
        logic [7:0]  held;
    } voice_state_t;

    logic              clk      = 1'b0;
    logic              rst_n    = 1'b0;
    logic              psel     = 1'b0;
    logic              penable  = 1'b0;
    logic              pwrite   = 1'b0;
    logic [APB_AW-1:0] paddr    = '0;
    logic [APB_DW-1:0] pwdata   = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [23:0]       s_tdata  = '0;  // load_address[15:0], load_byte[23:16]
    logic [1:0]        s_tuser  = '0;  // kind[1:0]
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [23:0]       m_tdata;        // sample_out[7:0], position[23:8]
    logic [0:0]        m_tuser;        // audible[0]

    // voice model: settings, playback state and sample memory
    cfg_t         voice_cfg;
    voice_state_t live_voice;
    voice_state_t plan_voice;
    logic [7:0]   voice_mem [0:MEM_DEPTH-1];
    bit           loaded [0:MEM_DEPTH-1];

    voice_beat_t  beats_to_send[$];
    voice_res_t   predicted_samples[$];
    voice_beat_t  on_wire;

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_left     = 0;
    int quiet         = 0;
    int errors        = 0;
    int beats_in      = 0;
    int results_out   = 0;
    int audible_seen  = 0;
    int reg_writes    = 0;
    int fill_loads    = 0;

    always #5 clk = ~clk;

    looped_sample_voice_pwm_volume DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // one beat of the voice; mem_byte is the memory cell at the current position
    function automatic voice_res_t voice_step(inout voice_state_t v, input cfg_t c,
                                              input kind_t k, input logic [7:0] mem_byte);
        voice_res_t  r;
        int unsigned len;
        int unsigned back;
        int unsigned nxt;
        r = '0;
        len = (c.sample_length == 0) ? 1 : ((c.sample_length > 65536) ? 65536
                                                                       : c.sample_length);
        if (k == KIND_START)
        begin
            v.pos = (c.start_offset < len - 1) ? c.start_offset : 16'(len - 1);
            v.active = 1'b1;
        end
        else if (k == KIND_TICK && v.active && c.volume != 0)
        begin
            if (v.div == 0)
            begin
                back = (c.loop_length == 0) ? 1 : c.loop_length;
                if (back > len)
                    back = len;
                nxt = v.pos + 1;
                v.held = mem_byte;
                // loop back only when stepping onto the end, otherwise count on
                v.pos = (nxt == len) ? 16'(len - back) : 16'(nxt);
                v.div = c.period;
            end
            if (v.pwm < c.volume)
            begin
                r.sample = v.held;
                r.audible = 1'b1;
            end
            v.pwm = v.pwm + 6'd1;
            v.div = v.div - 16'd1;
        end
        r.position = v.pos;
        return r;
    endfunction

    // queue a beat, loading the cell first when a tick would fetch an empty one
    function automatic void plan_beat(input kind_t k, input logic [15:0] a,
                                      input logic [7:0] d);
        voice_beat_t b;
        if (k == KIND_TICK && plan_voice.active && voice_cfg.volume != 0
            && plan_voice.div == 0 && !loaded[plan_voice.pos])
        begin
            loaded[plan_voice.pos] = 1'b1;
            b.kind = KIND_LOAD;
            b.addr = plan_voice.pos;
            b.data = 8'($urandom);
            beats_to_send.push_back(b);
            fill_loads++;
        end
        if (k == KIND_LOAD)
            loaded[a] = 1'b1;
        void'(voice_step(plan_voice, voice_cfg, k, 8'h00));
        b.kind = k;
        b.addr = a;
        b.data = d;
        beats_to_send.push_back(b);
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %h, got %h", name, want, got);
            errors++;
        end
    endfunction

    task automatic cfg_write(input reg_idx_t idx, input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'(int'(idx) * 4);
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_PERIOD:     voice_cfg.period        = value[15:0];
            REG_VOLUME:     voice_cfg.volume        = value[6:0];
            REG_SAMPLE_LEN: voice_cfg.sample_length = value[16:0];
            REG_LOOP_LEN:   voice_cfg.loop_length   = value[16:0];
            REG_START_OFS:  voice_cfg.start_offset  = value[15:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic set_voice(input int per, input int vol, input int len, input int lp,
                             input int ofs);
        cfg_write(REG_PERIOD, 32'(per));
        cfg_write(REG_VOLUME, 32'(vol));
        cfg_write(REG_SAMPLE_LEN, 32'(len));
        cfg_write(REG_LOOP_LEN, 32'(lp));
        cfg_write(REG_START_OFS, 32'(ofs));
    endtask

    // wait until every beat is sent and every result is back
    task automatic drain();
        while (beats_to_send.size() != 0 || s_tvalid || predicted_samples.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // input side
    always @(posedge clk)
    begin : drive
        voice_res_t r;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                r = voice_step(live_voice, voice_cfg, on_wire.kind,
                               voice_mem[live_voice.pos]);
                if (on_wire.kind == KIND_LOAD)
                    voice_mem[on_wire.addr] = on_wire.data;
                predicted_samples.push_back(r);
                beats_in++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (beats_to_send.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    on_wire = beats_to_send.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {on_wire.data, on_wire.addr};
                    s_tuser  <= on_wire.kind;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // output side
    always @(posedge clk)
    begin : watch
        voice_res_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (predicted_samples.size() == 0)
                begin
                    $error("result beat with nothing expected: %h", m_tdata);
                    errors++;
                end
                else
                begin
                    want = predicted_samples.pop_front();
                    check_field("sample_out", want.sample, m_tdata[7:0]);
                    check_field("audible", want.audible, m_tuser[0]);
                    check_field("position", want.position, m_tdata[23:8]);
                    results_out++;
                    if (m_tuser[0])
                        audible_seen++;
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || psel || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= QUIET_LIMIT)
        begin
            $display("looped_sample_voice_pwm_volume_tb NOT OK");
            $finish;
        end
    end

    initial
    begin : stimulus
        int per;
        int vol;
        int len;
        int lp;
        int ofs;
        int pick;
        voice_cfg.period        = PERIOD_RST;
        voice_cfg.volume        = '0;
        voice_cfg.sample_length = 17'd1;
        voice_cfg.loop_length   = 17'd1;
        voice_cfg.start_offset  = '0;
        live_voice = '0;
        plan_voice = '0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: idle voice, extreme bytes, no-op, zero volume freeze
        @(negedge clk);
        plan_beat(KIND_TICK, 16'hffff, 8'hff);
        plan_beat(KIND_LOAD, 16'h0000, 8'h80);
        plan_beat(KIND_LOAD, 16'hffff, 8'h7f);
        plan_beat(KIND_NOP, 16'hffff, 8'hff);
        plan_beat(KIND_START, 16'h0000, 8'h00);
        plan_beat(KIND_TICK, 16'h0000, 8'h00);
        drain();

        // short sample looping back over its last two bytes
        set_voice(1, 64, 4, 2, 0);
        @(negedge clk);
        plan_beat(KIND_START, 16'($urandom), 8'($urandom));
        repeat (6) plan_beat(KIND_TICK, 16'($urandom), 8'($urandom));
        drain();

        // start near the top, then shrink the length below the position
        set_voice(1, 65, 65536, 1, 65534);
        @(negedge clk);
        plan_beat(KIND_START, 16'($urandom), 8'($urandom));
        drain();
        set_voice(1, 127, 100, 131071, 65534);
        @(negedge clk);
        repeat (3) plan_beat(KIND_TICK, 16'($urandom), 8'($urandom));
        drain();

        for (int p = 0; p < PHASES; p++)
        begin
            per = ($urandom_range(3) == 0) ? $urandom_range(2, 40) : $urandom_range(1, 3);
            case ($urandom_range(7))
                0: vol = 0;
                1: vol = 1;
                2: vol = 64;
                3: vol = 65;
                4: vol = 127;
                default: vol = $urandom_range(1, 127);
            endcase
            case ($urandom_range(7))
                0: len = 0;
                1: len = 1;
                2: len = 65536;
                3: len = 131071;
                4: len = $urandom_range(2, 131071);
                default: len = $urandom_range(2, 48);
            endcase
            case ($urandom_range(5))
                0: lp = 0;
                1: lp = len;
                2: lp = 131071;
                default: lp = $urandom_range(1, 64);
            endcase
            case ($urandom_range(3))
                0: ofs = 0;
                1: ofs = 65535;
                default: ofs = $urandom_range(0, 80);
            endcase
            set_voice(per, vol, len, lp, ofs);

            @(negedge clk);
            case (p % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 72; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 72; end
                default: begin send_idle_pct = 38; stall_pct = 38; end
            endcase
            // long output hold-off so the voice backs up into its input
            if (p == 4)
                hold_left = HOLD_CYCLES;

            plan_beat(KIND_START, 16'($urandom), 8'($urandom));
            for (int i = 1; i < PHASE_BEATS; i++)
            begin
                pick = $urandom_range(99);
                if (pick < 4)
                    plan_beat(KIND_START, 16'($urandom), 8'($urandom));
                else if (pick < 7)
                    plan_beat(KIND_NOP, 16'($urandom), 8'($urandom));
                else if (pick < 20)
                    plan_beat(KIND_LOAD,
                              $urandom_range(1) ? 16'($urandom)
                                                : 16'(plan_voice.pos + $urandom_range(7)),
                              8'($urandom));
                else
                    plan_beat(KIND_TICK, 16'($urandom), 8'($urandom));
            end
            drain();
        end

        // period zero: the fetch reloads the divider to zero and it wraps
        @(negedge clk);
        send_idle_pct = 0;
        stall_pct = 0;
        set_voice(0, 127, 131071, 65536, 65535);
        @(negedge clk);
        plan_beat(KIND_START, 16'($urandom), 8'($urandom));
        do
            plan_beat(KIND_TICK, 16'($urandom), 8'($urandom));
        while (plan_voice.div != 16'hffff);
        repeat (2) plan_beat(KIND_TICK, 16'($urandom), 8'($urandom));
        drain();
        set_voice(65535, 127, 131071, 65536, 65535);
        @(negedge clk);
        repeat (2) plan_beat(KIND_TICK, 16'($urandom), 8'($urandom));
        drain();
        repeat (8) @(posedge clk);

        $display("%0d input beats (%0d fill loads), %0d results checked, %0d audible",
                 beats_in, fill_loads, results_out, audible_seen);
        $display("%0d register writes over edge and random settings, gaps and hold-off",
                 reg_writes);
        if (errors == 0 && predicted_samples.size() == 0)
            $display("looped_sample_voice_pwm_volume_tb OK");
        else
            $display("looped_sample_voice_pwm_volume_tb NOT OK");
        $finish;
    end

endmodule

FILE: looped_sample_voice_pwm_volume.f
+incdir+rtl
rtl/lsv_pkg.sv
rtl/lsv_regs.sv
rtl/looped_sample_voice_pwm_volume.sv
rtl/lsv_checker.sv
verif/looped_sample_voice_pwm_volume_tb.sv
